// ===== src/igmp_rge_pkg.sv =====
// Shared types and constants for the IGMPv3 report group extractor.
package igmp_rge_pkg;

    // Default packet length limit in bytes; later bytes are ignored.
    localparam int MAX_PACKET_BYTES_DEF = 256;

    // Reset value of the matched record type (change-to-exclude).
    localparam logic [7:0] MATCH_TYPE_RESET = 8'd4;

    // Protocol constants.
    localparam logic [3:0] IP_VERSION_4     = 4'd4;
    localparam logic [3:0] IHL_MIN          = 4'd5;
    localparam logic [7:0] IP_PROTO_IGMP    = 8'd2;
    localparam logic [7:0] IGMP_V3_REPORT   = 8'h22;
    localparam int         IP_PROTO_OFFSET  = 9;

    // Parse phase codes.
    localparam logic [2:0] PH_IP   = 3'd0;
    localparam logic [2:0] PH_IGMP = 3'd1;
    localparam logic [2:0] PH_REC  = 3'd2;
    localparam logic [2:0] PH_SKIP = 3'd3;
    localparam logic [2:0] PH_IDLE = 3'd4;

    // Byte positions within the IGMP header and within a group record.
    localparam logic [2:0] IDX_TYPE       = 3'd0;
    localparam logic [2:0] IDX_AUX_LEN    = 3'd1;
    localparam logic [2:0] IDX_COUNT_HI   = 3'd2;
    localparam logic [2:0] IDX_COUNT_LO   = 3'd3;
    localparam logic [2:0] IDX_NREC_HI    = 3'd6;
    localparam logic [2:0] IDX_LAST       = 3'd7;

    // One packet byte on the input channel.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    // One reported group on the output channel.
    typedef struct packed {
        logic [31:0] group_address;
        logic [15:0] record_number;
    } out_item_t;

    // Result handed from the parser to the output stage.
    typedef struct packed {
        logic      valid;
        out_item_t item;
    } result_t;

endpackage

// ===== src/igmp_rge_parser.sv =====
// Byte-wise IPv4/IGMPv3 parser that walks group records and flags matches.
module igmp_rge_parser #(
    parameter int MAX_PACKET_BYTES = igmp_rge_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_take,
    input  igmp_rge_pkg::in_item_t in_item,
    input  logic [7:0]             match_record_type,
    output igmp_rge_pkg::result_t  result
);
    import igmp_rge_pkg::*;

    localparam int OFFSET_W = $clog2(MAX_PACKET_BYTES + 1);

    logic [OFFSET_W-1:0] byte_offset_reg, byte_offset_next;
    logic [2:0]          parse_phase_reg, parse_phase_next;
    logic [5:0]          header_bytes_reg, header_bytes_next;
    logic [15:0]         records_left_reg, records_left_next;
    logic [15:0]         record_count_seen_reg, record_count_seen_next;
    logic [18:0]         skip_left_reg, skip_left_next;
    logic [2:0]          record_byte_index_reg, record_byte_index_next;
    logic [7:0]          current_record_type_reg, current_record_type_next;
    logic [7:0]          aux_words_reg, aux_words_next;
    logic [15:0]         source_count_reg, source_count_next;
    logic [31:0]         address_shift_reg, address_shift_next;

    logic [7:0]          b;
    logic                in_window;
    logic [15:0]         records_dec;
    logic [18:0]         skip_total;
    logic [18:0]         skip_dec;

    assign b           = in_item.data_byte;
    assign in_window   = byte_offset_reg < OFFSET_W'(MAX_PACKET_BYTES);
    assign records_dec = records_left_reg - 16'd1;
    assign skip_total  = {1'b0, source_count_reg, 2'b00}
                       + {9'd0, aux_words_reg, 2'b00};
    assign skip_dec    = (skip_left_reg != '0) ? skip_left_reg - 19'd1 : skip_left_reg;

    // Next-state logic for one accepted byte.
    always_comb begin
        byte_offset_next         = byte_offset_reg;
        parse_phase_next         = parse_phase_reg;
        header_bytes_next        = header_bytes_reg;
        records_left_next        = records_left_reg;
        record_count_seen_next   = record_count_seen_reg;
        skip_left_next           = skip_left_reg;
        record_byte_index_next   = record_byte_index_reg;
        current_record_type_next = current_record_type_reg;
        aux_words_next           = aux_words_reg;
        source_count_next        = source_count_reg;
        address_shift_next       = address_shift_reg;
        result.valid             = 1'b0;
        result.item.group_address = address_shift_reg;
        result.item.record_number = record_count_seen_reg;

        if (in_window) begin
            byte_offset_next = byte_offset_reg + 1'b1;
            unique case (parse_phase_reg)
                PH_IP: begin
                    if (byte_offset_reg == '0 &&
                        (b[7:4] != IP_VERSION_4 || b[3:0] < IHL_MIN)) begin
                        parse_phase_next = PH_IDLE;
                    end else if (byte_offset_reg == OFFSET_W'(IP_PROTO_OFFSET) &&
                                 b != IP_PROTO_IGMP) begin
                        parse_phase_next = PH_IDLE;
                    end else begin
                        if (byte_offset_reg == '0) begin
                            header_bytes_next = {b[3:0], 2'b00};
                        end
                        // Header length is known from byte 0 on.
                        if (byte_offset_reg + 1'b1 == OFFSET_W'(header_bytes_next)) begin
                            parse_phase_next       = PH_IGMP;
                            record_byte_index_next = '0;
                        end
                    end
                end
                PH_IGMP: begin
                    if (record_byte_index_reg == IDX_TYPE && b != IGMP_V3_REPORT) begin
                        parse_phase_next = PH_IDLE;
                    end else if (record_byte_index_reg == IDX_LAST) begin
                        records_left_next      = {records_left_reg[15:8], b};
                        record_count_seen_next = '0;
                        record_byte_index_next = '0;
                        parse_phase_next = ({records_left_reg[15:8], b} == '0) ?
                                           PH_IDLE : PH_REC;
                    end else begin
                        if (record_byte_index_reg == IDX_NREC_HI) begin
                            records_left_next = {b, 8'd0};
                        end
                        record_byte_index_next = record_byte_index_reg + 3'd1;
                    end
                end
                PH_REC: begin
                    case (record_byte_index_reg)
                        IDX_TYPE:     current_record_type_next = b;
                        IDX_AUX_LEN:  aux_words_next = b;
                        IDX_COUNT_HI: source_count_next = {b, 8'd0};
                        IDX_COUNT_LO: source_count_next = {source_count_reg[15:8], b};
                        default:      address_shift_next = {address_shift_reg[23:0], b};
                    endcase
                    if (record_byte_index_reg == IDX_LAST) begin
                        // Record header complete: report and set up the skip.
                        result.valid = (current_record_type_reg == match_record_type);
                        result.item.group_address = address_shift_next;
                        skip_left_next         = skip_total;
                        records_left_next      = records_dec;
                        record_count_seen_next = record_count_seen_reg + 16'd1;
                        record_byte_index_next = '0;
                        if (skip_total != '0) begin
                            parse_phase_next = PH_SKIP;
                        end else begin
                            parse_phase_next = (records_dec == '0) ? PH_IDLE : PH_REC;
                        end
                    end else begin
                        record_byte_index_next = record_byte_index_reg + 3'd1;
                    end
                end
                PH_SKIP: begin
                    skip_left_next = skip_dec;
                    if (skip_dec == '0) begin
                        record_byte_index_next = '0;
                        parse_phase_next = (records_left_reg == '0) ? PH_IDLE : PH_REC;
                    end
                end
                default: begin
                end
            endcase
        end

        // The final byte of a packet returns the parser to its start.
        if (in_item.last_byte) begin
            byte_offset_next         = '0;
            parse_phase_next         = PH_IP;
            header_bytes_next        = '0;
            records_left_next        = '0;
            record_count_seen_next   = '0;
            skip_left_next           = '0;
            record_byte_index_next   = '0;
            current_record_type_next = '0;
            aux_words_next           = '0;
            source_count_next        = '0;
            address_shift_next       = '0;
        end
        if (!in_take) begin
            result.valid = 1'b0;
        end
    end

    // Parse state registers, updated on each input transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_offset_reg         <= '0;
            parse_phase_reg         <= PH_IP;
            header_bytes_reg        <= '0;
            records_left_reg        <= '0;
            record_count_seen_reg   <= '0;
            skip_left_reg           <= '0;
            record_byte_index_reg   <= '0;
            current_record_type_reg <= '0;
            aux_words_reg           <= '0;
            source_count_reg        <= '0;
            address_shift_reg       <= '0;
        end else if (in_take) begin
            byte_offset_reg         <= byte_offset_next;
            parse_phase_reg         <= parse_phase_next;
            header_bytes_reg        <= header_bytes_next;
            records_left_reg        <= records_left_next;
            record_count_seen_reg   <= record_count_seen_next;
            skip_left_reg           <= skip_left_next;
            record_byte_index_reg   <= record_byte_index_next;
            current_record_type_reg <= current_record_type_next;
            aux_words_reg           <= aux_words_next;
            source_count_reg        <= source_count_next;
            address_shift_reg       <= address_shift_next;
        end
    end

endmodule

// ===== src/igmp_rge_out_stage.sv =====
// Output register with a skid entry; the input side waits only while both entries are full.
module igmp_rge_out_stage (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  igmp_rge_pkg::result_t   push,
    output logic                    push_ready,
    output logic                    m_valid,
    input  logic                    m_ready,
    output igmp_rge_pkg::out_item_t m_data
);
    import igmp_rge_pkg::*;

    logic      out_valid_reg;
    out_item_t out_data_reg;
    logic      skid_valid_reg;
    out_item_t skid_data_reg;
    logic      pop;

    assign pop        = out_valid_reg && m_ready;
    assign push_ready = !skid_valid_reg;
    assign m_valid    = out_valid_reg;
    assign m_data     = out_data_reg;

    // Valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= push.valid;
            end
        end else if (push.valid) begin
            if (out_valid_reg) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (pop) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else if (push.valid) begin
                out_data_reg <= push.item;
            end
        end else if (push.valid) begin
            if (out_valid_reg) begin
                skid_data_reg <= push.item;
            end else begin
                out_data_reg <= push.item;
            end
        end
    end

endmodule

// ===== src/igmpv3_report_group_extractor.sv =====
// Top level of the IGMPv3 membership report group extractor.
//
// The s_ channel takes one IPv4 packet byte per transfer, starting at header
// byte 0, with last_byte set on the final byte. The block checks IP version 4,
// protocol IGMP and report type 0x22, walks the group records, and for each
// record whose type equals the configured value sends the group address and
// record index on the m_ channel. Other packets produce nothing.
// The cfg_ channel writes the record type to match; cfg_ready is always high.
// One byte is accepted per cycle when s_ready is high. A result is registered
// in the output stage on the transfer of the last byte of its record header.
// A two-entry output register (output plus skid entry) parts the channels:
// s_ready drops only while both entries hold results the receiver has not
// taken, so a stalled receiver backs up the input after two pending results.
// Reset clears all parse state, empties the output, and sets the matched type
// to 4 (change-to-exclude). Bytes past MAX_PACKET_BYTES are ignored until
// last_byte.
module igmpv3_report_group_extractor #(
    parameter int MAX_PACKET_BYTES = igmp_rge_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  igmp_rge_pkg::in_item_t  s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output igmp_rge_pkg::out_item_t m_data,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [7:0]              cfg_data
);
    import igmp_rge_pkg::*;

    logic [7:0] match_record_type_reg;
    logic       in_take;
    result_t    result;

    assign cfg_ready = 1'b1;
    assign in_take   = s_valid && s_ready;

    // Matched record type register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_record_type_reg <= MATCH_TYPE_RESET;
        end else if (cfg_valid) begin
            match_record_type_reg <= cfg_data;
        end
    end

    igmp_rge_parser #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_parser (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .in_take           (in_take),
        .in_item           (s_data),
        .match_record_type (match_record_type_reg),
        .result            (result)
    );

    igmp_rge_out_stage u_out_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (result),
        .push_ready (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
